// ===== rtl/sop_pkg.sv =====
// ----------------------------------------------------------------------------
// sop_pkg
// Types and constants for the scroll offset pacer: register indexes, field
// widths, size limits and the sequencer state type.
// ----------------------------------------------------------------------------
package sop_pkg;

    // Field and register widths
    localparam int ELAPSED_W   = 8;
    localparam int X_W         = 13;
    localparam int Y_W         = 8;
    localparam int SPEED_W     = 6;
    localparam int MODE_W      = 2;
    localparam int TW_W        = 11;
    localparam int MW_W        = 8;
    localparam int HT_W        = 8;
    localparam int ACC_W       = 10;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 11;

    // Size limits applied when a width register is written
    localparam int MAX_TEXT_WIDTH   = 2047;
    localparam int MAX_MATRIX_WIDTH = 255;

    // Frame period numerator and accumulator ceiling
    localparam int MS_PER_SEC  = 1000;
    localparam int ACC_MAX     = 1023;

    // Divider: one quotient bit per dividend bit
    localparam int DIV_STEPS   = 10;
    localparam int CNT_W       = 4;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SPEED     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DIRECTION = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MODE      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TEXT_W    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MATRIX_W  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_TEXT_H    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_MATRIX_H  = 3'd6;

    // Scroll modes
    localparam logic [MODE_W-1:0] MODE_NONE     = 2'd0;
    localparam logic [MODE_W-1:0] MODE_INFINITE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_BOUNCE   = 2'd2;
    localparam logic [MODE_W-1:0] MODE_INF_ALT  = 2'd3;

    // Scroll directions
    localparam logic DIR_LEFT  = 1'b0;
    localparam logic DIR_RIGHT = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_DIV,
        ST_CMP,
        ST_FRAME
    } t_state;

endpackage

// ===== rtl/scroll_offset_pacer_unit.sv =====
// ----------------------------------------------------------------------------
// scroll_offset_pacer_unit
// Paces a scrolling text banner and gives x/y text offsets for each frame.
// ----------------------------------------------------------------------------
// Each transfer on the input channel reports the milliseconds elapsed since
// the previous one; they add into an accumulator that saturates at 1023. The
// first transfer after reset always yields a frame. Later transfers yield a
// frame only when scroll_speed is nonzero and the accumulator has reached
// 1000/scroll_speed; each frame clears the accumulator and produces one
// output transfer with a horizontal offset (per scroll mode) and a vertical
// centering offset. From acceptance back to ready, the first frame passes
// through the decide and frame states, and an item with scroll_speed zero
// through decide alone. Every other item passes through decide, runs the
// restoring divider, which forms 1000/scroll_speed one quotient bit per
// cycle, then a compare state, and the frame state if it yields a frame.
// A frame waits in its final state only while the output register still
// holds an untaken result. Write configuration registers only while the
// block is idle.
// ----------------------------------------------------------------------------
module scroll_offset_pacer_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // input channel
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [sop_pkg::ELAPSED_W-1:0]       i_elapsed_ms,
    // output channel
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic signed [sop_pkg::X_W-1:0]      o_x_offset,
    output logic signed [sop_pkg::Y_W-1:0]      o_y_offset,
    // configuration write port
    input  logic                                i_cfg_we,
    input  logic [sop_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [sop_pkg::CFG_DATA_W-1:0]      i_cfg_data
);
    import sop_pkg::*;

    // Configuration registers
    logic [SPEED_W-1:0] r_speed;
    logic               r_direction;
    logic [MODE_W-1:0]  r_mode;
    logic [TW_W-1:0]    r_text_w;
    logic [MW_W-1:0]    r_matrix_w;
    logic [HT_W-1:0]    r_text_h;
    logic [HT_W-1:0]    r_matrix_h;

    // Sequencer and pacing state
    t_state             r_state,      n_state;
    logic [ACC_W-1:0]   r_acc,        n_acc;
    logic [ACC_W-1:0]   r_ms,         n_ms;
    logic               r_frame_done, n_frame_done;
    logic [X_W-1:0]     r_step,       n_step;

    // Divider
    logic [SPEED_W-1:0] r_rem,        n_rem;
    logic [ACC_W-1:0]   r_dvd,        n_dvd;
    logic [ACC_W-1:0]   r_quot,       n_quot;
    logic [CNT_W-1:0]   r_cnt,        n_cnt;

    // Output register
    logic               r_out_valid,  n_out_valid;
    logic [X_W-1:0]     r_x,          n_x;
    logic [Y_W-1:0]     r_y,          n_y;

    // Datapath intermediates
    logic [ACC_W:0]         w_sum;
    logic [SPEED_W:0]       w_trial;
    logic                   w_ge;
    logic signed [14:0]     w_s, w_s1, w_tw, w_mw, w_d, w_d2, w_sb, w_xb;
    logic [X_W-1:0]         w_s1_13;
    logic [X_W-1:0]         w_x_frame, w_step_frame;
    logic signed [8:0]      w_ydiff, w_ysum, w_yshift;

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_x_offset  = r_x;
    assign o_y_offset  = r_y;

    // ------------------------------------------------------------------
    // Configuration writes; clamp widths to their limits
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_speed     <= SPEED_W'(1);
            r_direction <= DIR_LEFT;
            r_mode      <= MODE_INFINITE;
            r_text_w    <= '0;
            r_matrix_w  <= MW_W'(32);
            r_text_h    <= HT_W'(8);
            r_matrix_h  <= HT_W'(16);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_SPEED:     r_speed     <= i_cfg_data[SPEED_W-1:0];
                REG_DIRECTION: r_direction <= i_cfg_data[0];
                REG_MODE:      r_mode      <= i_cfg_data[MODE_W-1:0];
                REG_TEXT_W: begin
                    if (32'(i_cfg_data[TW_W-1:0]) > MAX_TEXT_WIDTH) begin
                        r_text_w <= TW_W'(MAX_TEXT_WIDTH);
                    end else begin
                        r_text_w <= i_cfg_data[TW_W-1:0];
                    end
                end
                REG_MATRIX_W: begin
                    if (32'(i_cfg_data[MW_W-1:0]) > MAX_MATRIX_WIDTH) begin
                        r_matrix_w <= MW_W'(MAX_MATRIX_WIDTH);
                    end else begin
                        r_matrix_w <= i_cfg_data[MW_W-1:0];
                    end
                end
                REG_TEXT_H:    r_text_h    <= i_cfg_data[HT_W-1:0];
                REG_MATRIX_H:  r_matrix_h  <= i_cfg_data[HT_W-1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Datapath pieces
    // ------------------------------------------------------------------
    // saturating accumulate of the incoming item
    assign w_sum = {1'b0, r_ms} + (ACC_W + 1)'(i_elapsed_ms);

    // one restoring-division step: shift in the next dividend bit, trial
    // subtract the speed
    assign w_trial = {r_rem, r_dvd[ACC_W-1]};
    assign w_ge    = (w_trial >= {1'b0, r_speed});

    // horizontal offset for the frame
    always_comb begin
        w_s     = 15'(signed'(r_step));
        w_s1_13 = r_step + X_W'(1);
        w_s1    = 15'(signed'(w_s1_13));
        w_tw    = signed'(15'(r_text_w));
        w_mw    = signed'(15'(r_matrix_w));
        w_d     = (w_mw > w_tw) ? (w_mw - w_tw) : (w_tw - w_mw);
        w_d2    = w_d <<< 1;
        w_sb    = (w_s == w_d2) ? 15'sd0 : w_s;
        w_xb    = (w_sb < w_d) ? w_sb : (w_d2 - w_sb);
        if (w_tw > w_mw) begin
            w_xb = -w_xb;
        end

        w_x_frame    = '0;
        w_step_frame = r_step;
        case (r_mode)
            MODE_NONE: begin
                w_x_frame    = '0;
                w_step_frame = r_step;
            end
            MODE_BOUNCE: begin
                if (w_tw == w_mw) begin
                    // equal widths: park the text, leave the counter alone
                    w_x_frame    = '0;
                    w_step_frame = r_step;
                end else begin
                    w_x_frame    = w_xb[X_W-1:0];
                    w_step_frame = w_sb[X_W-1:0] + X_W'(1);
                end
            end
            default: begin
                // infinite scroll, both mode codes
                if (r_direction == DIR_LEFT) begin
                    w_x_frame    = X_W'(-w_s);
                    w_step_frame = (w_s1 >= w_tw) ? X_W'(-w_mw) : w_s1_13;
                end else begin
                    w_x_frame    = r_step;
                    w_step_frame = (w_s1 >= w_mw) ? X_W'(-w_tw) : w_s1_13;
                end
            end
        endcase
    end

    // vertical centering, truncated toward zero
    always_comb begin
        w_ydiff  = signed'({1'b0, r_matrix_h}) - signed'({1'b0, r_text_h});
        w_ysum   = w_ydiff + signed'(9'(w_ydiff[8]));
        w_yshift = w_ysum >>> 1;
    end

    // ------------------------------------------------------------------
    // Sequencer: next state and register updates
    // ------------------------------------------------------------------
    always_comb begin
        n_state      = r_state;
        n_acc        = r_acc;
        n_ms         = r_ms;
        n_frame_done = r_frame_done;
        n_step       = r_step;
        n_rem        = r_rem;
        n_dvd        = r_dvd;
        n_quot       = r_quot;
        n_cnt        = r_cnt;
        n_out_valid  = r_out_valid;
        n_x          = r_x;
        n_y          = r_y;

        // retire the held result once it is taken
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_acc   = w_sum[ACC_W] ? ACC_W'(ACC_MAX) : w_sum[ACC_W-1:0];
                    n_state = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                if (!r_frame_done) begin
                    n_state = ST_FRAME;
                end else if (r_speed == '0) begin
                    // frozen: keep accumulating, no frame
                    n_ms    = r_acc;
                    n_state = ST_IDLE;
                end else begin
                    n_rem   = '0;
                    n_dvd   = ACC_W'(MS_PER_SEC);
                    n_quot  = '0;
                    n_cnt   = '0;
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                n_rem  = w_ge ? SPEED_W'(w_trial - {1'b0, r_speed})
                              : w_trial[SPEED_W-1:0];
                n_dvd  = {r_dvd[ACC_W-2:0], 1'b0};
                n_quot = {r_quot[ACC_W-2:0], w_ge};
                n_cnt  = r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(DIV_STEPS - 1)) begin
                    n_state = ST_CMP;
                end
            end
            ST_CMP: begin
                if (r_acc < r_quot) begin
                    n_ms    = r_acc;
                    n_state = ST_IDLE;
                end else begin
                    n_state = ST_FRAME;
                end
            end
            ST_FRAME: begin
                // hold until the output register is free
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid  = 1'b1;
                    n_x          = w_x_frame;
                    n_y          = w_yshift[Y_W-1:0];
                    n_step       = w_step_frame;
                    n_ms         = '0;
                    n_frame_done = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_ms         <= '0;
            r_frame_done <= 1'b0;
            r_step       <= '0;
            r_cnt        <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_ms         <= n_ms;
            r_frame_done <= n_frame_done;
            r_step       <= n_step;
            r_cnt        <= n_cnt;
            r_out_valid  <= n_out_valid;
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        r_acc  <= n_acc;
        r_rem  <= n_rem;
        r_dvd  <= n_dvd;
        r_quot <= n_quot;
        r_x    <= n_x;
        r_y    <= n_y;
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // a frame clears the accumulator and marks the first frame as done
    a_frame_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FRAME && (!r_out_valid || i_out_ready))
        |=> (r_frame_done && r_ms == '0 && r_out_valid))
        else $error("frame did not clear accumulator or load output");

    // divider never runs past its last step
    a_div_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV) |-> (r_cnt <= CNT_W'(DIV_STEPS - 1)))
        else $error("divider step count out of range");

    // 1000/speed is at least 15 for any 6-bit nonzero speed
    a_quot_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CMP) |-> (r_quot >= ACC_W'(15)))
        else $error("frame period quotient too small");

    // centering offset stays inside -127..127
    a_y_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_y != 8'h80))
        else $error("y offset out of range");

    // a skipped item leaves the frame flag set and the output untouched
    a_skip_no_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CMP && r_acc < r_quot && !r_out_valid) |=> !r_out_valid)
        else $error("output produced for a skipped item");

endmodule

// ===== tb/tb_scroll_offset_pacer_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_scroll_offset_pacer_unit
// Self-checking bench for the scroll offset pacer. A frame predictor tracks
// the accumulator, the step counter and the register file. It turns every
// accepted millisecond transfer into the frame offsets that the block owes.
// Output transfers are checked against those, oldest first. Stimulus runs in
// this order: a directed part, then random setups under three idling profiles
// with one long output stall.
// ----------------------------------------------------------------------------
module tb_scroll_offset_pacer_unit;

    import sop_pkg::*;

    localparam int CLK_HALF_NS   = 10;
    localparam int RESET_CYCLES  = 6;
    localparam int SETTLE_CYCLES = 24;
    localparam int HOLD_CYCLES   = 400;     // long output stall
    localparam int SETUPS        = 6;       // random setups per idling profile
    localparam int ITEMS_PER_SET = 50;
    localparam longint TIMEOUT_NS = 64'd50_000_000;

    // ------------------------------------------------------------------------
    // Frame predictor and store of expected offsets
    // ------------------------------------------------------------------------
    typedef struct {
        logic signed [X_W-1:0] x;
        logic signed [Y_W-1:0] y;
    } t_frame;

    class scroll_frame_board;
        logic [SPEED_W-1:0] speed;
        logic               dir;
        logic [MODE_W-1:0]  mode;
        logic [TW_W-1:0]    tw;
        logic [MW_W-1:0]    mw;
        logic [HT_W-1:0]    th;
        logic [HT_W-1:0]    mh;
        logic [X_W-1:0]     step;
        logic [ACC_W-1:0]   acc_ms;
        bit                 framed;
        t_frame             frames[$];
        int                 errors;

        function new();
            speed  = SPEED_W'(1);
            dir    = DIR_LEFT;
            mode   = MODE_INFINITE;
            tw     = '0;
            mw     = MW_W'(32);
            th     = HT_W'(8);
            mh     = HT_W'(16);
            step   = '0;
            acc_ms = '0;
            framed = 1'b0;
            errors = 0;
        endfunction

        function int pending();
            return frames.size();
        endfunction

        function int wrap13(int v);
            logic signed [X_W-1:0] t;
            t = v[X_W-1:0];
            return int'(t);
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_SPEED:     speed = data[SPEED_W-1:0];
                REG_DIRECTION: dir   = data[0];
                REG_MODE:      mode  = data[MODE_W-1:0];
                REG_TEXT_W: begin
                    tw = data[TW_W-1:0];
                    if (int'(tw) > MAX_TEXT_WIDTH) tw = TW_W'(MAX_TEXT_WIDTH);
                end
                REG_MATRIX_W: begin
                    mw = data[MW_W-1:0];
                    if (int'(mw) > MAX_MATRIX_WIDTH) mw = MW_W'(MAX_MATRIX_WIDTH);
                end
                REG_TEXT_H:    th = data[HT_W-1:0];
                REG_MATRIX_H:  mh = data[HT_W-1:0];
                default: ;
            endcase
        endfunction

        // Note one accepted input transfer; queue a frame if it causes one.
        function void note_input(logic [ELAPSED_W-1:0] ms);
            int sum, s, ns, d, x, y, tw_i, mw_i;
            t_frame fr;
            sum = int'(acc_ms) + int'(ms);
            if (sum > ACC_MAX) sum = ACC_MAX;
            if (framed && (speed == 0 || sum < MS_PER_SEC / int'(speed))) begin
                acc_ms = ACC_W'(sum);
                return;
            end
            acc_ms = '0;
            framed = 1'b1;
            x      = 0;
            y      = (int'(mh) - int'(th)) / 2;
            tw_i   = int'(tw);
            mw_i   = int'(mw);
            s      = wrap13(int'(step));
            if (mode == MODE_BOUNCE) begin
                if (tw_i != mw_i) begin
                    d = (mw_i > tw_i) ? mw_i - tw_i : tw_i - mw_i;
                    if (s == 2 * d) s = 0;
                    x = (s < d) ? s : 2 * d - s;
                    if (tw_i > mw_i) x = -x;
                    step = X_W'(s + 1);
                end
            end else if (mode != MODE_NONE) begin
                if (dir == DIR_LEFT) begin
                    x  = -s;
                    ns = wrap13(s + 1);
                    if (ns >= tw_i) ns = -mw_i;
                end else begin
                    x  = s;
                    ns = wrap13(s + 1);
                    if (ns >= mw_i) ns = -tw_i;
                end
                step = X_W'(ns);
            end
            fr.x = x[X_W-1:0];
            fr.y = y[Y_W-1:0];
            frames.push_back(fr);
        endfunction

        // Compare one output transfer with the oldest expected frame.
        function void check_result(logic signed [X_W-1:0] x, logic signed [Y_W-1:0] y);
            t_frame fr;
            if (frames.size() == 0) begin
                errors++;
                $display("%0t: unexpected frame, x_offset %0d y_offset %0d", $time, x, y);
                return;
            end
            fr = frames.pop_front();
            if (x !== fr.x) begin
                errors++;
                $display("%0t: x_offset mismatch, expected %0d, got %0d", $time, fr.x, x);
            end
            if (y !== fr.y) begin
                errors++;
                $display("%0t: y_offset mismatch, expected %0d, got %0d", $time, fr.y, y);
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Block ports; every input starts at a known value
    // ------------------------------------------------------------------------
    logic                          i_clk        = 1'b0;
    logic                          i_rst_n      = 1'b0;
    logic                          i_in_valid   = 1'b0;
    logic                          o_in_ready;
    logic [ELAPSED_W-1:0]          i_elapsed_ms = '0;
    logic                          o_out_valid;
    logic                          i_out_ready  = 1'b0;
    logic signed [X_W-1:0]         o_x_offset;
    logic signed [Y_W-1:0]         o_y_offset;
    logic                          i_cfg_we     = 1'b0;
    logic [CFG_IDX_W-1:0]          i_cfg_index  = '0;
    logic [CFG_DATA_W-1:0]         i_cfg_data   = '0;

    scroll_frame_board board = new();

    // Idle odds in percent, changed per phase by the stimulus process
    int  send_idle_pct = 0;
    int  recv_idle_pct = 0;
    // Raised by the stimulus to ask the receiver for one long stall
    bit  hold_out = 1'b0;

    scroll_offset_pacer_unit dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_elapsed_ms (i_elapsed_ms),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_x_offset   (o_x_offset),
        .o_y_offset   (o_y_offset),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    initial begin
        forever #(CLK_HALF_NS) i_clk = ~i_clk;
    end

    // Run limit: far beyond the slowest correct run
    initial begin
        #(TIMEOUT_NS);
        $display("%0t: timeout, %0d frames still owed", $time, board.pending());
        $display("Simulation FAILED");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Receiver: check each output transfer, then pick ready for the next edge.
    // Signals are read right after the edge, before the block's own updates
    // land, so every sample is the value the edge itself saw.
    // ------------------------------------------------------------------------
    initial begin
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && i_out_ready)
                board.check_result(o_x_offset, o_y_offset);
            if (hold_out) begin
                // Drop ready for a long stretch so the block backs up into
                // its input channel while the sender keeps offering.
                hold_out = 1'b0;
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // ------------------------------------------------------------------------
    // Driving tasks
    // ------------------------------------------------------------------------

    // Offer one millisecond transfer and hold it until accepted. Valid is left
    // high on return; the next call either keeps it high or idles first.
    task automatic send_elapsed(input logic [ELAPSED_W-1:0] ms);
        if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_elapsed_ms <= ms;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        // Note the transfer here, in the same process, so that the predictor
        // is current before the caller looks at it.
        board.note_input(ms);
    endtask

    // Stop offering, wait until every owed frame is out, then let a trailing
    // item that makes no frame run to its end.
    task automatic drain_block();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (board.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        board.write_reg(idx, data);
    endtask

    // Write the whole register file; call only while the block is idle.
    task automatic load_setup(input logic [SPEED_W-1:0] speed, input logic dir,
                              input logic [MODE_W-1:0] mode, input logic [TW_W-1:0] tw,
                              input logic [MW_W-1:0] mw, input logic [HT_W-1:0] th,
                              input logic [HT_W-1:0] mh);
        cfg_write(REG_SPEED,     CFG_DATA_W'(speed));
        cfg_write(REG_DIRECTION, CFG_DATA_W'(dir));
        cfg_write(REG_MODE,      CFG_DATA_W'(mode));
        cfg_write(REG_TEXT_W,    CFG_DATA_W'(tw));
        cfg_write(REG_MATRIX_W,  CFG_DATA_W'(mw));
        cfg_write(REG_TEXT_H,    CFG_DATA_W'(th));
        cfg_write(REG_MATRIX_H,  CFG_DATA_W'(mh));
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [HT_W-1:0] pick_height();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            default: return HT_W'($urandom_range(0, 255));
        endcase
    endfunction

    // Pick a random setup, leaning on the extremes, and load it.
    task automatic load_random_setup();
        logic [SPEED_W-1:0] speed;
        logic [TW_W-1:0]    tw;
        logic [MW_W-1:0]    mw;
        case ($urandom_range(0, 9))
            0:       speed = SPEED_W'(0);
            1:       speed = SPEED_W'(1);
            2:       speed = SPEED_W'(63);
            3:       speed = SPEED_W'(60);
            default: speed = SPEED_W'($urandom_range(1, 63));
        endcase
        case ($urandom_range(0, 5))
            0:       tw = '0;
            1:       tw = TW_W'(MAX_TEXT_WIDTH);
            2, 3:    tw = TW_W'($urandom_range(0, MAX_TEXT_WIDTH));
            default: tw = TW_W'($urandom_range(0, 300));
        endcase
        case ($urandom_range(0, 5))
            0:       mw = '0;
            1:       mw = MW_W'(MAX_MATRIX_WIDTH);
            2:       mw = MW_W'(1);
            default: mw = MW_W'($urandom_range(0, 255));
        endcase
        // Equal widths now and then freeze bounce
        if ($urandom_range(0, 7) == 0) tw = TW_W'(mw);
        load_setup(speed, 1'($urandom_range(0, 1)), MODE_W'($urandom_range(0, 3)),
                   tw, mw, pick_height(), pick_height());
    endtask

    function automatic logic [ELAPSED_W-1:0] pick_elapsed();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            default: return ELAPSED_W'($urandom_range(0, 255));
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_idle_pct = 18;
        recv_idle_pct = 56;

        // Reset setup: the first item always frames, then 1000 ms are needed
        send_elapsed(8'd0);
        repeat (4) send_elapsed(8'd255);

        // Speed zero: no frames; accumulator climbs to its ceiling and stays
        drain_block();
        load_setup(6'd0, DIR_LEFT, MODE_NONE, 11'd0, 8'd32, 8'd255, 8'd0);
        repeat (5) send_elapsed(8'd255);

        // Saturated accumulator frames at once when speed returns
        drain_block();
        load_setup(6'd1, DIR_LEFT, MODE_NONE, 11'd2047, 8'd255, 8'd0, 8'd255);
        send_elapsed(8'd0);

        // Fastest speed: period is exactly 15 ms; equal widths hold bounce;
        // odd negative height difference truncates toward zero
        drain_block();
        load_setup(6'd63, DIR_RIGHT, MODE_BOUNCE, 11'd40, 8'd40, 8'd7, 8'd0);
        send_elapsed(8'd15);
        send_elapsed(8'd14);
        send_elapsed(8'd1);

        // Mode three runs as infinite, scrolling right
        drain_block();
        load_setup(6'd63, DIR_RIGHT, MODE_INF_ALT, 11'd3, 8'd2, 8'd9, 8'd200);
        repeat (3) send_elapsed(8'd255);

        // Text wider than the matrix: bounce offsets come out negated
        drain_block();
        load_setup(6'd60, DIR_LEFT, MODE_BOUNCE, 11'd10, 8'd4, 8'd1, 8'd4);
        repeat (4) send_elapsed(8'd255);

        // Random setups under three idling profiles
        for (int phase = 0; phase < 3; phase++) begin
            drain_block();
            case (phase)
                0: begin send_idle_pct = 18; recv_idle_pct = 56; end
                1: begin send_idle_pct = 56; recv_idle_pct = 18; end
                default: begin send_idle_pct = 0; recv_idle_pct = 0; end
            endcase
            if (phase == 2) begin
                // Every item frames at top speed; stall the output meanwhile
                load_setup(6'd63, 1'($urandom_range(0, 1)), MODE_W'($urandom_range(0, 3)),
                           TW_W'($urandom_range(0, 300)), MW_W'($urandom_range(0, 255)),
                           pick_height(), pick_height());
                hold_out = 1'b1;
                repeat (ITEMS_PER_SET) send_elapsed(8'd255);
                drain_block();
            end
            for (int k = 0; k < SETUPS; k++) begin
                load_random_setup();
                repeat (ITEMS_PER_SET) send_elapsed(pick_elapsed());
                drain_block();
            end
        end

        drain_block();
        if (board.errors == 0 && board.pending() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/sop_pkg.sv
rtl/scroll_offset_pacer_unit.sv
tb/tb_scroll_offset_pacer_unit.sv
